// ===== rtl/tcpst_pkg.sv =====
// shared types, constants and the next-state lookup table for the tcp session state tracker
package tcpst_pkg;

    localparam int SESSIONS  = 1024;
    localparam int SESS_AW   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int IDX_W     = 10;
    localparam int FLAGS_W   = 8;
    localparam int STATE_W   = 4;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [STATE_W-1:0] {
        ST_NO, ST_SS, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_TW, ST_CL, ST_S2, ST_IV, ST_IG
    } state_t;

    typedef enum logic [2:0] {
        CL_SYN, CL_SYNACK, CL_FIN, CL_ACK, CL_RST, CL_NONE
    } pkt_class_t;

    typedef enum logic [1:0] {
        VD_OK, VD_FAIL, VD_IGN
    } verdict_t;

    typedef enum logic {
        OP_OPEN, OP_TRACK
    } op_t;

    localparam logic [FLAGS_W-1:0] F_FIN  = 8'h01;
    localparam logic [FLAGS_W-1:0] F_SYN  = 8'h02;
    localparam logic [FLAGS_W-1:0] F_RST  = 8'h04;
    localparam logic [FLAGS_W-1:0] F_ACK  = 8'h10;
    localparam logic [FLAGS_W-1:0] F_URG  = 8'h20;
    localparam logic [FLAGS_W-1:0] F_CARE = 8'h37;

    typedef struct packed {
        verdict_t   verdict;
        logic       flags_valid;
        pkt_class_t pkt_class;
        state_t     state;
        logic       est_mark;
        logic       wr_en;
    } lookup_res_t;

    // next state by direction, packet class and old state
    localparam state_t NS_TAB [0:1][0:5][0:9] = '{
        '{
            '{ST_SS, ST_SS, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_SS, ST_SS, ST_S2},
            '{ST_IV, ST_IV, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_SR},
            '{ST_IV, ST_IV, ST_FW, ST_FW, ST_LA, ST_LA, ST_LA, ST_TW, ST_CL, ST_IV},
            '{ST_ES, ST_ES, ST_ES, ST_ES, ST_CW, ST_CW, ST_TW, ST_TW, ST_CL, ST_IV},
            '{ST_IV, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL},
            '{ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV}
        },
        '{
            '{ST_IV, ST_S2, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_S2},
            '{ST_IV, ST_SR, ST_SR, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_SR},
            '{ST_IV, ST_IV, ST_FW, ST_FW, ST_LA, ST_LA, ST_LA, ST_TW, ST_CL, ST_IV},
            '{ST_IV, ST_IG, ST_SR, ST_ES, ST_CW, ST_CW, ST_TW, ST_TW, ST_CL, ST_IG},
            '{ST_IV, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL},
            '{ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV}
        }
    };

    function automatic pkt_class_t classify(input logic [FLAGS_W-1:0] flags);
        logic [FLAGS_W-1:0] f;
        pkt_class_t c;
        f = flags & F_CARE;
        case (f) inside
            F_SYN, F_SYN | F_URG:                 c = CL_SYN;
            F_SYN | F_ACK:                        c = CL_SYNACK;
            F_RST, F_RST | F_ACK:                 c = CL_RST;
            F_FIN | F_ACK, F_FIN | F_ACK | F_URG: c = CL_FIN;
            F_ACK, F_ACK | F_URG:                 c = CL_ACK;
            default:                              c = CL_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/tcpst_ram.sv =====
// generic single write port ram with registered read
module tcpst_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tcpst_lookup.sv =====
// flag classification and state transition lookup for one word
module tcpst_lookup import tcpst_pkg::*; (
    input  op_t                op,
    input  logic [IDX_W-1:0]   idx,
    input  logic               dir,
    input  logic [FLAGS_W-1:0] flags,
    input  logic [STATE_W-1:0] old_raw,
    output lookup_res_t        res
);

    pkt_class_t         cls;
    state_t             old_c;
    state_t             ns;
    logic               in_range;
    logic               open_ok;
    logic [FLAGS_W-1:0] g;

    always_comb begin
        cls      = classify(flags);
        old_c    = (old_raw > STATE_W'(ST_S2)) ? ST_NO : state_t'(old_raw);
        ns       = NS_TAB[dir][cls][old_c];
        in_range = (32'(idx) < 32'(SESSIONS));
        g        = flags & F_CARE & ~F_URG;
        open_ok  = (g == F_SYN) || (g == F_ACK);
    end

    always_comb begin
        res.verdict     = VD_FAIL;
        res.flags_valid = (cls != CL_NONE);
        res.pkt_class   = cls;
        res.state       = ST_NO;
        res.est_mark    = 1'b0;
        res.wr_en       = 1'b0;
        if (in_range) begin
            res.state = old_c;
            unique case (op)
                OP_OPEN: begin
                    if (open_ok) begin
                        res.verdict = VD_OK;
                        res.state   = ST_NO;
                        res.wr_en   = 1'b1;
                    end
                end
                OP_TRACK: begin
                    if (ns == ST_IV) begin
                        res.verdict = VD_FAIL;
                    end else if (ns == ST_IG) begin
                        res.verdict = VD_IGN;
                    end else begin
                        res.verdict  = VD_OK;
                        res.state    = ns;
                        res.wr_en    = 1'b1;
                        res.est_mark = (ns == ST_ES);
                    end
                end
                default: begin
                    res.verdict = VD_FAIL;
                end
            endcase
        end
    end

endmodule

// ===== rtl/tcp_session_state_tracker.sv =====
// top level of the tcp session state tracker
// Takes one word per cycle while the output side accepts results; back-pressure on m_tready
// stalls the input stage. The accept edge reads the 1024 x 4 session state ram into the
// input stage; once the output register is free, the flag lookup is applied, the new state
// is written back and the output register is loaded. Words that hit the same session back
// to back see the state just written through a bypass from the ram write port. Entries
// hold no defined value until an open writes them; there is no clearing pass after reset,
// so the block takes words as soon as reset drops.
module tcp_session_state_tracker import tcpst_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // session_index [9:0], direction [10], tcp_flags [18:11], zero [23:19]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation [0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // verdict [1:0], flags_valid [2], packet_class [5:3], session_state_out [9:6],
    // established_mark [10], zero [15:11]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic                  s_hs;
    logic                  s1_adv;
    logic                  ram_we;
    logic [STATE_W-1:0]    ram_rdata;
    logic [STATE_W-1:0]    old_raw;
    logic [IDX_W-1:0]      s_idx;
    logic                  byp_hit_next;
    lookup_res_t           res;

    logic                  s1_valid_reg;
    op_t                   s1_op_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic                  s1_dir_reg;
    logic [FLAGS_W-1:0]    s1_flags_reg;
    logic                  byp_hit_reg;
    logic [STATE_W-1:0]    byp_data_reg;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_DATA_W-1:0] m_data_next;

    assign s_idx    = s_tdata[IDX_W-1:0];
    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_hs     = s_tvalid && s_tready;
    assign ram_we   = s1_valid_reg && s1_adv && res.wr_en;
    assign old_raw  = byp_hit_reg ? byp_data_reg : ram_rdata;

    // same session written while this word read the ram
    assign byp_hit_next = ram_we && (s1_idx_reg == s_idx);

    tcpst_ram #(
        .WIDTH (STATE_W),
        .DEPTH (SESSIONS)
    ) u_state_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (SESS_AW'(s1_idx_reg)),
        .wdata (res.state),
        .re    (s_hs),
        .raddr (SESS_AW'(s_idx)),
        .rdata (ram_rdata)
    );

    tcpst_lookup u_lookup (
        .op      (s1_op_reg),
        .idx     (s1_idx_reg),
        .dir     (s1_dir_reg),
        .flags   (s1_flags_reg),
        .old_raw (old_raw),
        .res     (res)
    );

    assign m_data_next = {5'b0, res.est_mark, res.state, res.pkt_class,
                          res.flags_valid, res.verdict};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_hs) begin
            s1_op_reg    <= op_t'(s_tuser);
            s1_idx_reg   <= s_idx;
            s1_dir_reg   <= s_tdata[IDX_W];
            s1_flags_reg <= s_tdata[IDX_W+FLAGS_W:IDX_W+1];
            byp_hit_reg  <= byp_hit_next;
            byp_data_reg <= res.state;
        end
        if (s1_valid_reg && s1_adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_we_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> s1_valid_reg && s1_adv)
        else $error("state write without a word leaving the input stage");

    a_est_means_es: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && res.est_mark) |-> (res.state == ST_ES) && res.wr_en
            && (res.verdict == VD_OK))
        else $error("established mark without a stored es state");

    a_bypass_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_hs && ram_we && (s1_idx_reg == s_idx)) |=> byp_hit_reg && s1_valid_reg)
        else $error("back to back word on one session missed the bypass");

    a_fail_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (res.verdict != VD_OK)) |-> !ram_we)
        else $error("state written on a failed or ignored word");
`endif

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the tcp session state tracker with a predicting scoreboard
module testbench;
    import tcpst_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int RAND_WORDS  = 750;
    localparam int LANES       = 4;

    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   idx;
        logic               dir;
        logic [FLAGS_W-1:0] flags;
    } pkt_word_t;

    typedef struct packed {
        verdict_t   verdict;
        logic       flags_valid;
        pkt_class_t pclass;
        state_t     state;
        logic       est;
    } session_result_t;

    class session_state_predictor;
        state_t          sess_state [SESSIONS];
        state_t          next_tab [0:1][0:5][0:9];
        session_result_t expected_results [$];
        int errors = 0;
        int n_checked = 0;
        int n_open = 0;
        int n_track = 0;
        int n_est = 0;
        int n_ign = 0;
        int n_fail = 0;

        function new();
            foreach (sess_state[i]) sess_state[i] = ST_NO;
            next_tab = '{
                '{
                    '{ST_SS, ST_SS, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_SS, ST_SS, ST_S2},
                    '{ST_IV, ST_IV, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_SR},
                    '{ST_IV, ST_IV, ST_FW, ST_FW, ST_LA, ST_LA, ST_LA, ST_TW, ST_CL, ST_IV},
                    '{ST_ES, ST_ES, ST_ES, ST_ES, ST_CW, ST_CW, ST_TW, ST_TW, ST_CL, ST_IV},
                    '{ST_IV, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL},
                    '{ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV}
                },
                '{
                    '{ST_IV, ST_S2, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_S2},
                    '{ST_IV, ST_SR, ST_SR, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_IG, ST_SR},
                    '{ST_IV, ST_IV, ST_FW, ST_FW, ST_LA, ST_LA, ST_LA, ST_TW, ST_CL, ST_IV},
                    '{ST_IV, ST_IG, ST_SR, ST_ES, ST_CW, ST_CW, ST_TW, ST_TW, ST_CL, ST_IG},
                    '{ST_IV, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL},
                    '{ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV, ST_IV}
                }
            };
        endfunction

        function pkt_class_t class_of(logic [FLAGS_W-1:0] f);
            pkt_class_t c;
            case (f)
                F_SYN, F_SYN | F_URG:                 c = CL_SYN;
                F_SYN | F_ACK:                        c = CL_SYNACK;
                F_RST, F_RST | F_ACK:                 c = CL_RST;
                F_FIN | F_ACK, F_FIN | F_ACK | F_URG: c = CL_FIN;
                F_ACK, F_ACK | F_URG:                 c = CL_ACK;
                default:                              c = CL_NONE;
            endcase
            return c;
        endfunction

        function void note_word(pkt_word_t w);
            logic [FLAGS_W-1:0] f;
            logic [FLAGS_W-1:0] g;
            session_result_t r;
            state_t old;
            state_t ns;
            f = w.flags & F_CARE;
            g = f & ~F_URG;
            r.pclass = class_of(f);
            r.flags_valid = (r.pclass != CL_NONE);
            r.verdict = VD_FAIL;
            r.est = 1'b0;
            old = sess_state[w.idx];
            r.state = old;
            if (w.op == OP_OPEN) begin
                n_open++;
                if (g == F_SYN || g == F_ACK) begin
                    r.state = ST_NO;
                    r.verdict = VD_OK;
                    sess_state[w.idx] = ST_NO;
                end
            end else begin
                n_track++;
                ns = next_tab[w.dir][r.pclass][old];
                if (ns == ST_IV) begin
                    r.verdict = VD_FAIL;
                end else if (ns == ST_IG) begin
                    r.verdict = VD_IGN;
                end else begin
                    r.verdict = VD_OK;
                    r.state = ns;
                    r.est = (ns == ST_ES);
                    sess_state[w.idx] = ns;
                end
            end
            if (r.est) n_est++;
            if (r.verdict == VD_IGN) n_ign++;
            if (r.verdict == VD_FAIL) n_fail++;
            expected_results.push_back(r);
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] d);
            session_result_t e;
            if (expected_results.size() == 0) begin
                $error("result word with no expectation waiting: %h", d);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            n_checked++;
            if (d[1:0] !== e.verdict) begin
                $error("verdict: expected %0d, got %0d", e.verdict, d[1:0]);
                errors++;
            end
            if (d[2] !== e.flags_valid) begin
                $error("flags_valid: expected %0d, got %0d", e.flags_valid, d[2]);
                errors++;
            end
            if (d[5:3] !== e.pclass) begin
                $error("packet_class: expected %0d, got %0d", e.pclass, d[5:3]);
                errors++;
            end
            if (d[9:6] !== e.state) begin
                $error("session_state_out: expected %0d, got %0d", e.state, d[9:6]);
                errors++;
            end
            if (d[10] !== e.est) begin
                $error("established_mark: expected %0d, got %0d", e.est, d[10]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // session_index [9:0], direction [10], tcp_flags [18:11], zero [23:19]
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // operation [0]
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // verdict [1:0], flags_valid [2], packet_class [5:3], session_state_out [9:6],
    // established_mark [10], zero [15:11]
    logic [OUT_DATA_W-1:0] m_tdata;

    session_state_predictor sb = new();
    int        idle_pct = 28;
    bit        hold_off_req = 1'b0;
    int        cycle_count = 0;
    bit        opened [SESSIONS];
    int        opened_list [$];
    pkt_word_t flow_lane [LANES][$];

    tcp_session_state_tracker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    // receiver: random back-pressure plus one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    function automatic void mark_opened(int idx);
        if (!opened[idx]) begin
            opened[idx] = 1'b1;
            opened_list.push_back(idx);
        end
    endfunction

    // a session counts as opened only once a successful open has been accepted
    task automatic send_word(input pkt_word_t w);
        logic [FLAGS_W-1:0] g;
        g = w.flags & F_CARE & ~F_URG;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {{(IN_DATA_W - IDX_W - 1 - FLAGS_W){1'b0}}, w.flags, w.dir, w.idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w);
        if (w.op == OP_OPEN && (g == F_SYN || g == F_ACK)) mark_opened(int'(w.idx));
    endtask

    task automatic send_fields(input op_t op, input logic [IDX_W-1:0] idx, input logic dir,
                               input logic [FLAGS_W-1:0] flags);
        pkt_word_t w;
        w.op = op;
        w.idx = idx;
        w.dir = dir;
        w.flags = flags;
        send_word(w);
    endtask

    // legal flags for a class, with psh, ece and cwr riding along
    function automatic logic [FLAGS_W-1:0] flags_for(pkt_class_t c);
        logic [FLAGS_W-1:0] f;
        f = FLAGS_W'($urandom) & ~F_CARE;
        case (c)
            CL_SYN:    f |= F_SYN | ($urandom_range(1) ? F_URG : '0);
            CL_SYNACK: f |= F_SYN | F_ACK;
            CL_FIN:    f |= F_FIN | F_ACK | ($urandom_range(1) ? F_URG : '0);
            CL_ACK:    f |= F_ACK | ($urandom_range(1) ? F_URG : '0);
            CL_RST:    f |= F_RST | ($urandom_range(1) ? F_ACK : '0);
            default:   f = '0;
        endcase
        return f;
    endfunction

    function automatic void queue_word(int ln, op_t op, logic [IDX_W-1:0] idx, logic dir,
                                       pkt_class_t c);
        pkt_word_t w;
        w.op = op;
        w.idx = idx;
        w.dir = dir;
        w.flags = flags_for(c);
        flow_lane[ln].push_back(w);
    endfunction

    // one connection lifetime: handshake, data, teardown or reset, sometimes cut short
    function automatic void build_flow(int ln);
        logic [IDX_W-1:0] idx;
        int  kind;
        logic a;
        idx = IDX_W'($urandom_range(SESSIONS - 1));
        kind = $urandom_range(3);
        a = 1'($urandom_range(1));
        queue_word(ln, OP_OPEN, idx, 1'b0, (kind == 2) ? CL_ACK : CL_SYN);
        if (kind == 2) begin
            queue_word(ln, OP_TRACK, idx, 1'b0, CL_ACK);
        end else begin
            queue_word(ln, OP_TRACK, idx, 1'b0, CL_SYN);
            if (kind == 1) queue_word(ln, OP_TRACK, idx, 1'b1, CL_SYN);
            queue_word(ln, OP_TRACK, idx, 1'b1, CL_SYNACK);
            queue_word(ln, OP_TRACK, idx, 1'b0, CL_ACK);
        end
        repeat ($urandom_range(3))
            queue_word(ln, OP_TRACK, idx, 1'($urandom_range(1)), CL_ACK);
        if (kind == 3) begin
            queue_word(ln, OP_TRACK, idx, a, CL_RST);
        end else begin
            queue_word(ln, OP_TRACK, idx, a, CL_FIN);
            queue_word(ln, OP_TRACK, idx, ~a, CL_ACK);
            queue_word(ln, OP_TRACK, idx, ~a, CL_FIN);
            queue_word(ln, OP_TRACK, idx, a, CL_ACK);
        end
        if ($urandom_range(3) == 0)
            flow_lane[ln] = flow_lane[ln][0:$urandom_range(flow_lane[ln].size() - 1)];
    endfunction

    // stray word: only opened sessions are read, successful opens may land anywhere
    task automatic send_noise();
        pkt_word_t w;
        logic [FLAGS_W-1:0] g;
        w.op = op_t'($urandom_range(1));
        w.dir = 1'($urandom_range(1));
        w.flags = $urandom_range(1) ? FLAGS_W'($urandom)
                                    : flags_for(pkt_class_t'($urandom_range(4)));
        g = w.flags & F_CARE & ~F_URG;
        if (w.op == OP_OPEN && (g == F_SYN || g == F_ACK)) begin
            w.idx = IDX_W'($urandom_range(SESSIONS - 1));
        end else begin
            w.idx = IDX_W'(opened_list[$urandom_range(opened_list.size() - 1)]);
        end
        send_word(w);
    endtask

    initial begin
        int ln;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        mark_opened(0);
        mark_opened(SESSIONS - 1);
        send_fields(OP_OPEN,  10'd0,    1'b0, F_SYN);
        send_fields(OP_OPEN,  10'd1023, 1'b0, F_ACK | F_URG | ~F_CARE);
        send_fields(OP_OPEN,  10'd0,    1'b0, 8'hFF);
        send_fields(OP_OPEN,  10'd0,    1'b1, 8'h00);
        send_fields(OP_TRACK, 10'd0,    1'b0, 8'h00);
        send_fields(OP_TRACK, 10'd0,    1'b0, 8'hFF);
        send_fields(OP_TRACK, 10'd0,    1'b1, F_SYN);
        send_fields(OP_TRACK, 10'd0,    1'b0, F_SYN | F_URG);
        send_fields(OP_TRACK, 10'd0,    1'b0, F_SYN);
        send_fields(OP_TRACK, 10'd0,    1'b1, F_SYN | F_ACK);
        send_fields(OP_TRACK, 10'd0,    1'b1, F_SYN | F_ACK);
        send_fields(OP_TRACK, 10'd0,    1'b0, F_SYN | F_ACK);
        send_fields(OP_TRACK, 10'd0,    1'b0, F_ACK);
        send_fields(OP_TRACK, 10'd1023, 1'b0, F_ACK);
        send_fields(OP_TRACK, 10'd1023, 1'b0, F_FIN | F_ACK | F_URG);
        send_fields(OP_TRACK, 10'd1023, 1'b1, F_RST);
        send_fields(OP_TRACK, 10'd1023, 1'b0, F_RST | F_ACK);
        send_fields(OP_TRACK, 10'd0,    1'b1, F_FIN | F_ACK);
        send_fields(OP_TRACK, 10'd0,    1'b0, F_ACK);
        send_fields(OP_TRACK, 10'd0,    1'b1, F_ACK);
        send_fields(OP_OPEN,  10'd0,    1'b0, F_SYN);
        send_fields(OP_TRACK, 10'd0,    1'b0, F_RST);

        for (int n = 0; n < RAND_WORDS; n++) begin
            idle_pct = (n >= 250 && n < 450) ? 0 : 28;
            if (n == 300) hold_off_req = 1'b1;
            if ($urandom_range(99) < 80) begin
                ln = $urandom_range(LANES - 1);
                if (flow_lane[ln].size() == 0) build_flow(ln);
                send_word(flow_lane[ln].pop_front());
            end else begin
                send_noise();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("run covered %0d words: %0d opens and %0d tracks over %0d sessions",
                 sb.n_open + sb.n_track, sb.n_open, sb.n_track, opened_list.size());
        $display("%0d results checked: %0d established, %0d ignored, %0d failed, %0d mismatches",
                 sb.n_checked, sb.n_est, sb.n_ign, sb.n_fail, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
